[design/bsum_pkg.sv]
// Shared constants and types for the 3x3 zero-padded box sum.
// No dependencies; the interfaces, the cell and the top module import this package.
package bsum_pkg;

	localparam int MAX_COLS  = 1024;
	localparam int SAMPLE_W  = 16;
	localparam int ADDR_W    = $clog2(MAX_COLS);
	localparam int ROWS_W    = 13;
	localparam int COLS_W    = ADDR_W + 1;
	localparam int COLSUM_W  = SAMPLE_W + 2;
	localparam int SUM_W     = SAMPLE_W + 4;
	localparam int CFG_W     = (ROWS_W > COLS_W) ? ROWS_W : COLS_W;
	localparam int CFG_IDX_W = 1;

	localparam int OUT_DEPTH = 4;
	localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
	localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

	localparam logic [ROWS_W-1:0] ROWS_RESET = ROWS_W'(4);
	localparam logic [COLS_W-1:0] COLS_RESET = COLS_W'(4);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ROWS = 1'b0,
		CFG_COLS = 1'b1
	} cfg_idx_t;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [COLSUM_W-1:0] colsum_t;
	typedef logic signed [SUM_W-1:0]    sum_t;

	// one window column: three vertically adjacent samples
	typedef struct packed {
		sample_t top;
		sample_t mid;
		sample_t bot;
	} col_t;

endpackage

[design/bsum_if.sv]
// Valid/ready channels carrying the sample words in and the result words out.
// Depends on bsum_pkg for the payload types.
interface bsum_in_if;
	import bsum_pkg::*;

	logic    valid;
	logic    ready;
	logic    op;
	sample_t value;

	modport source (output valid, output op, output value, input ready);
	modport sink   (input valid, input op, input value, output ready);
endinterface

interface bsum_out_if;
	import bsum_pkg::*;

	logic valid;
	logic ready;
	sum_t sum;
	logic last;

	modport source (output valid, output sum, output last, input ready);
	modport sink   (input valid, input sum, input last, output ready);
endinterface

[design/bsum_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Read during write to the same address returns the old contents.
module bsum_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

[design/bsum_cell.sv]
// One window cell: holds a column of three samples and its column sum.
// Depends on bsum_pkg; cells are chained so each hands its column on.
module bsum_cell (
	input  logic           clk,
	input  logic           en,
	input  logic           clr,
	input  bsum_pkg::col_t din,
	output bsum_pkg::col_t dout,
	output bsum_pkg::colsum_t sum
);
	import bsum_pkg::*;

	col_t col_q;

	always_ff @(posedge clk) begin
		if (en) begin
			col_q <= clr ? '0 : din;
		end
	end

	assign dout = col_q;
	assign sum  = COLSUM_W'(col_q.top) + COLSUM_W'(col_q.mid) + COLSUM_W'(col_q.bot);
endmodule

[design/box_sum_3x3_zero_padded_top.sv]
// 3x3 box sum with zero padding over a raster-order matrix of signed samples.
// Depends on bsum_pkg, bsum_if, bsum_ram and bsum_cell.
//
// Usage:
//   pixel  : valid/ready words {op, value}, rows*cols samples in raster order,
//            then one row of cols drain words (op = 1) for the zero row below.
//   result : valid/ready words {sum, last}; last marks the final position.
//   cfg    : cfg_we/cfg_index/cfg_data write rows or cols; any write restarts
//            the frame. Write only while the block is idle.
// The result for centre (r, c) is formed from the word at (r+1, c+1); at the
// last column one word gives two results. A result word is registered in
// stage 1 and then written to the output queue.
// Throughput is one word per cycle while pixel.ready is high: one line-store
// read and one write per cycle, and the two-cell window shifts once per word.
// A four-word output queue decouples the receiver; when it holds more than two
// words that are not being taken, pixel.ready drops and the pipeline holds.
// Reset sets rows and cols to 4 and the position to row 0, column 0. The line
// stores need no clearing: rows above the matrix are masked by position.
module box_sum_3x3_zero_padded_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  bsum_pkg::cfg_idx_t             cfg_index,
	input  logic [bsum_pkg::CFG_W-1:0]     cfg_data,
	bsum_in_if.sink                        pixel,
	bsum_out_if.source                     result
);
	import bsum_pkg::*;

	typedef struct packed {
		sample_t           x;
		logic [ADDR_W-1:0] col;
		logic              r_ge1;
		logic              r_ge2;
		logic              first;
		logic              lastc;
		logic              drain;
		logic              fwd;
		sample_t           fwd_near;
		sample_t           fwd_far;
	} s1_t;

	typedef struct packed {
		sum_t sum;
		logic last;
	} res_t;

	logic [ROWS_W-1:0] rows_q;
	logic [COLS_W-1:0] cols_q;
	logic [ROWS_W-1:0] row_q;
	logic [ADDR_W-1:0] col_q;

	logic [ROWS_W-1:0] nr;
	logic [COLS_W-1:0] nc;
	logic              out_of_range;
	logic [ROWS_W-1:0] cur_r;
	logic [ADDR_W-1:0] cur_c;
	logic              cur_drain;
	logic              cur_lastc;
	sample_t           cur_x;

	logic    adv;
	logic    accept;
	logic    pop;
	logic    s1_v_q;
	s1_t     s1_q;

	logic [SAMPLE_W-1:0] near_rdata;
	logic [SAMPLE_W-1:0] far_rdata;
	sample_t             near_rd;
	sample_t             far_rd;
	sample_t             top;
	sample_t             mid;
	colsum_t             cur;
	logic                wr_en;

	col_t    c0_din;
	col_t    c0_dout;
	col_t    c1_dout;
	colsum_t c0_sum;
	colsum_t c1_sum;

	sum_t    sum1;
	sum_t    sum2;
	logic    res1;
	logic    res2;

	res_t                 fifo_q [OUT_DEPTH];
	logic [OUT_PTR_W-1:0] wr_q;
	logic [OUT_PTR_W-1:0] rd_q;
	logic [OUT_CNT_W-1:0] count_q;

	// effective geometry: clamp registers to the legal range
	assign nr = (rows_q == '0) ? ROWS_W'(1) : rows_q;
	assign nc = (cols_q == '0) ? COLS_W'(1) :
		((cols_q > COLS_W'(MAX_COLS)) ? COLS_W'(MAX_COLS) : cols_q);

	assign out_of_range = (row_q > nr) || ({1'b0, col_q} >= nc);
	assign cur_r        = out_of_range ? '0 : row_q;
	assign cur_c        = out_of_range ? '0 : col_q;
	assign cur_drain    = (cur_r == nr);
	assign cur_lastc    = ({1'b0, cur_c} == (nc - COLS_W'(1)));
	assign cur_x        = (cur_drain || pixel.op) ? '0 : pixel.value;

	// output queue needs room for two words before the pipeline may advance
	assign pop    = result.valid && result.ready;
	assign adv    = (count_q <= OUT_CNT_W'(OUT_DEPTH - 2)) ||
		(pop && (count_q == OUT_CNT_W'(OUT_DEPTH - 1)));
	assign accept = pixel.valid && adv;
	assign pixel.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= ROWS_RESET;
			cols_q <= COLS_RESET;
			row_q  <= '0;
			col_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ROWS: rows_q <= cfg_data[ROWS_W-1:0];
				CFG_COLS: cols_q <= cfg_data[COLS_W-1:0];
				default: begin
				end
			endcase
			row_q <= '0;
			col_q <= '0;
		end else if (accept) begin
			if (cur_lastc) begin
				col_q <= '0;
				row_q <= cur_drain ? '0 : cur_r + ROWS_W'(1);
			end else begin
				col_q <= cur_c + ADDR_W'(1);
				row_q <= cur_r;
			end
		end
	end

	// line stores: read at accept, write when the word leaves stage 1
	assign wr_en = adv && s1_v_q;

	bsum_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_COLS)) u_near (
		.clk   (clk),
		.we    (wr_en),
		.waddr (s1_q.col),
		.wdata (s1_q.x),
		.re    (accept),
		.raddr (cur_c),
		.rdata (near_rdata)
	);

	bsum_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_COLS)) u_far (
		.clk   (clk),
		.we    (wr_en),
		.waddr (s1_q.col),
		.wdata (mid),
		.re    (accept),
		.raddr (cur_c),
		.rdata (far_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
		end else if (adv) begin
			s1_v_q <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s1_q.x     <= cur_x;
			s1_q.col   <= cur_c;
			s1_q.r_ge1 <= (cur_r != '0);
			s1_q.r_ge2 <= (cur_r > ROWS_W'(1));
			s1_q.first <= (cur_c == '0);
			s1_q.lastc <= cur_lastc;
			s1_q.drain <= cur_drain;
			// same column written in this cycle: the store returns stale data
			s1_q.fwd      <= s1_v_q && (s1_q.col == cur_c);
			s1_q.fwd_near <= s1_q.x;
			s1_q.fwd_far  <= mid;
		end
	end

	assign near_rd = s1_q.fwd ? s1_q.fwd_near : sample_t'(near_rdata);
	assign far_rd  = s1_q.fwd ? s1_q.fwd_far  : sample_t'(far_rdata);
	assign top     = s1_q.r_ge2 ? far_rd  : '0;
	assign mid     = s1_q.r_ge1 ? near_rd : '0;
	assign cur     = COLSUM_W'(top) + COLSUM_W'(mid) + COLSUM_W'(s1_q.x);
	assign c0_din  = '{top: top, mid: mid, bot: s1_q.x};

	// window: newest column in cell 0, older column in cell 1
	bsum_cell u_cell0 (
		.clk  (clk),
		.en   (wr_en),
		.clr  (1'b0),
		.din  (c0_din),
		.dout (c0_dout),
		.sum  (c0_sum)
	);

	bsum_cell u_cell1 (
		.clk  (clk),
		.en   (wr_en),
		.clr  (s1_q.first),
		.din  (c0_dout),
		.dout (c1_dout),
		.sum  (c1_sum)
	);

	assign sum1 = SUM_W'(c1_sum) + SUM_W'(c0_sum) + SUM_W'(cur);
	assign sum2 = (s1_q.first ? '0 : SUM_W'(c0_sum)) + SUM_W'(cur);
	assign res1 = s1_v_q && s1_q.r_ge1 && !s1_q.first;
	assign res2 = s1_v_q && s1_q.r_ge1 && s1_q.lastc;

	always_ff @(posedge clk) begin
		if (adv) begin
			if (res1) begin
				fifo_q[wr_q] <= '{sum: sum1, last: 1'b0};
			end
			if (res2) begin
				fifo_q[res1 ? wr_q + OUT_PTR_W'(1) : wr_q] <= '{sum: sum2, last: s1_q.drain};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (adv) begin
				wr_q <= wr_q + OUT_PTR_W'(res1) + OUT_PTR_W'(res2);
			end
			if (pop) begin
				rd_q <= rd_q + OUT_PTR_W'(1);
			end
			count_q <= count_q
				+ (adv ? OUT_CNT_W'(res1) + OUT_CNT_W'(res2) : OUT_CNT_W'(0))
				- OUT_CNT_W'(pop);
		end
	end

	assign result.valid = (count_q != '0);
	assign result.sum   = fifo_q[rd_q].sum;
	assign result.last  = fifo_q[rd_q].last;

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= OUT_CNT_W'(OUT_DEPTH))
		else $error("output queue overfilled");

	a_last_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_v_q && s1_q.drain && s1_q.lastc) |-> (row_q == '0 && col_q == '0))
		else $error("frame end word did not return position to origin");

	a_cfg_restart: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> (row_q == '0 && col_q == '0))
		else $error("register write did not restart the frame");
endmodule
